/* hw/rtl/sfrle_pkg.sv */
// ----------------------------------------------------------------------------
// sfrle_pkg
// Shared types and constants of the serial frame run-length encoder.
// ----------------------------------------------------------------------------
package sfrle_pkg;

  localparam int DATA_W      = 8;
  localparam int COUNT_W     = 4;
  localparam int RUN_W       = 8;
  localparam int MODE_W      = 2;

  // level sequence of one frame: start, 8 data, parity, 2 stop at most
  localparam int LEV_W       = 12;
  localparam int NLEV_W      = 4;

  localparam int BIT_TICKS_DEF = 16;

  localparam logic [MODE_W-1:0] MODE_8N1 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_8E2 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PWM = 2'd2;

  localparam logic [COUNT_W-1:0] MAX_PWM_BITS = 4'd8;
  localparam logic [RUN_W-1:0]   PWM_ONE_TICKS  = 8'd24;
  localparam logic [RUN_W-1:0]   PWM_ZERO_TICKS = 8'd16;

  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

  // one classified byte, levels stored in line order from bit 0
  typedef struct packed {
    logic              pwm;
    logic [LEV_W-1:0]  lev;
    logic [NLEV_W-1:0] nlev;
  } job_t;

endpackage

/* hw/rtl/sfrle_if.sv */
// ----------------------------------------------------------------------------
// sfrle_if
// Valid/ready channels for input bytes and output runs.
// ----------------------------------------------------------------------------
interface sfrle_in_if;
  import sfrle_pkg::*;

  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  data_byte;
  logic [COUNT_W-1:0] bit_count;

  modport source (output valid, output data_byte, output bit_count, input ready);
  modport sink   (input valid, input data_byte, input bit_count, output ready);
endinterface

interface sfrle_out_if;
  import sfrle_pkg::*;

  logic             valid;
  logic             ready;
  logic [RUN_W-1:0] run_ticks_minus_one;
  logic             last_run;

  modport source (output valid, output run_ticks_minus_one, output last_run, input ready);
  modport sink   (input valid, input run_ticks_minus_one, input last_run, output ready);
endinterface

/* hw/rtl/sfrle_front.sv */
// ----------------------------------------------------------------------------
// sfrle_front
// Holds the mode register, accepts bytes and builds the level sequence.
// ----------------------------------------------------------------------------
module sfrle_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sfrle_pkg::MODE_W-1:0] cfg_wdata,
  sfrle_in_if.sink                    in_ch,
  output logic                        push,
  output sfrle_pkg::job_t             push_job,
  input  logic                        push_ready
);
  import sfrle_pkg::*;

  logic [MODE_W-1:0]  frame_mode_r;
  logic [MODE_W-1:0]  frame_mode_nxt;
  logic [COUNT_W-1:0] cnt;
  logic               parity;
  logic               keep;

  always_comb begin
    frame_mode_nxt = cfg_we ? cfg_wdata : frame_mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_mode_r <= MODE_8N1;
    end else begin
      frame_mode_r <= frame_mode_nxt;
    end
  end

  always_comb begin
    cnt      = (in_ch.bit_count > MAX_PWM_BITS) ? MAX_PWM_BITS : in_ch.bit_count;
    parity   = ^in_ch.data_byte;
    push_job = '0;
    keep     = 1'b0;
    case (frame_mode_r)
      MODE_8N1: begin
        push_job.lev  = {2'b00, 1'b1, in_ch.data_byte, 1'b0};
        push_job.nlev = 4'd10;
        keep          = 1'b1;
      end
      MODE_8E2: begin
        push_job.lev  = {2'b11, parity, in_ch.data_byte, 1'b0};
        push_job.nlev = 4'd12;
        keep          = 1'b1;
      end
      MODE_PWM: begin
        push_job.pwm = 1'b1;
        // msb first on the line, so reverse into bit 0 order
        for (int i = 0; i < DATA_W; i++) begin
          push_job.lev[i] = in_ch.data_byte[DATA_W-1-i];
        end
        push_job.nlev = cnt;
        keep          = (cnt != '0);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // bytes that produce no run are taken and dropped
  assign in_ch.ready = push_ready;
  assign push        = in_ch.valid && push_ready && keep;

endmodule

/* hw/rtl/sfrle_queue.sv */
// ----------------------------------------------------------------------------
// sfrle_queue
// Short job queue between the classifier and the run generator.
// ----------------------------------------------------------------------------
module sfrle_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sfrle_pkg::job_t push_job,
  output logic            push_ready,
  input  logic            pop,
  output logic            head_valid,
  output sfrle_pkg::job_t head_job
);
  import sfrle_pkg::*;

  job_t              mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_nxt;

  assign push_ready = (cnt_r != QCNT_W'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !push_ready))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_valid))
    else $error("pop from empty queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(Q_DEPTH))
    else $error("queue count out of range");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count missed a push");

endmodule

/* hw/rtl/sfrle_back.sv */
// ----------------------------------------------------------------------------
// sfrle_back
// Walks the level sequence of a job: one run per cycle unless out_ch stalls.
// ----------------------------------------------------------------------------
module sfrle_back #(
  parameter int BIT_TICKS = sfrle_pkg::BIT_TICKS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  sfrle_pkg::job_t head_job,
  output logic            pop,
  sfrle_out_if.source     out_ch
);
  import sfrle_pkg::*;

  localparam logic [8:0] BT = 9'(BIT_TICKS);

  logic             busy_r;
  logic             busy_nxt;
  job_t             job_r;
  job_t             job_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [RUN_W-1:0] out_run_r;
  logic [RUN_W-1:0] out_run_nxt;
  logic             out_last_r;
  logic             out_last_nxt;

  job_t              cur;
  logic              cur_valid;
  logic [NLEV_W-1:0] nb;
  logic              run_on;
  logic              last;
  logic [8:0]        ticks;
  logic              adv;

  always_comb begin
    cur       = busy_r ? job_r : head_job;
    cur_valid = busy_r || head_valid;

    // length in bits of the run at the head of the remaining levels
    nb     = 4'd1;
    run_on = !cur.pwm;
    for (int i = 1; i < LEV_W; i++) begin
      if (run_on && (NLEV_W'(i) < cur.nlev) && (cur.lev[i] == cur.lev[0])) begin
        nb = nb + 4'd1;
      end else begin
        run_on = 1'b0;
      end
    end
    last = (nb == cur.nlev);

    if (cur.pwm) begin
      ticks = {1'b0, cur.lev[0] ? PWM_ONE_TICKS : PWM_ZERO_TICKS};
    end else begin
      ticks = 9'({5'd0, nb} * BT);
    end

    adv = cur_valid && (!out_valid_r || out_ch.ready);
    pop = adv && !busy_r;

    job_nxt      = cur;
    job_nxt.lev  = cur.lev >> nb;
    job_nxt.nlev = cur.nlev - nb;

    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_run_nxt   = out_run_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      busy_nxt      = !last;
      out_valid_nxt = 1'b1;
      out_run_nxt   = RUN_W'(ticks - 9'd1);
      out_last_nxt  = last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job_r <= job_nxt;
    end
    out_run_r  <= out_run_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.run_ticks_minus_one = out_run_r;
  assign out_ch.last_run            = out_last_r;

  a_busy_has_levels: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (job_r.nlev != '0))
    else $error("run generator busy with no levels left");

  a_run_fits: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> (nb <= cur.nlev))
    else $error("run longer than remaining levels");

  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last) |=> !busy_r)
    else $error("job continues after its last run");

  a_pwm_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && cur.pwm) |-> (nb == 4'd1))
    else $error("pwm run spans several bits");

endmodule

/* hw/rtl/serial_frame_run_length_encoder.sv */
// The first run of a byte passes the job queue, then the output register.
// One run per cycle from a single run generator while the output is not stalled,
// and a byte gives up to 10 runs in 8N1 and 8E2, one per bit (max 8) in PWM.
// A 2-entry job queue lets bytes be taken while runs are still in flight.
// Reset: synchronous, active low; mode returns to 8N1, queue and output empty.
// ----------------------------------------------------------------------------
// serial_frame_run_length_encoder
// Turns bytes into run lengths of serial line levels in 8N1, 8E2 or PWM form.
// ----------------------------------------------------------------------------
module serial_frame_run_length_encoder #(
  parameter int BIT_TICKS = sfrle_pkg::BIT_TICKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [sfrle_pkg::MODE_W-1:0] cfg_wdata,
  sfrle_in_if.sink                     in_ch,
  sfrle_out_if.source                  out_ch
);
  import sfrle_pkg::*;

  logic push;
  job_t push_job;
  logic push_ready;
  logic pop;
  logic head_valid;
  job_t head_job;

  sfrle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  sfrle_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  sfrle_back #(
    .BIT_TICKS (BIT_TICKS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
